/* hdl/assert_macros.svh */
// Assertion macros shared by the round-robin task selector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rrts_pkg.sv */
// Shared types, codes and constants of the round-robin task selector.
package rrts_pkg;

  localparam int PID_W           = 6;
  localparam int FUNC_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int TPU_W           = 10;
  localparam int WORD_W          = 32;
  localparam int TS_W            = 2;
  localparam int DEF_TABLE_SLOTS = 64;

  localparam logic [TPU_W-1:0] TPU_RESET = 10'd1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD       = 3'd0,
    FN_REMOVE    = 3'd1,
    FN_BLOCK     = 3'd2,
    FN_WAKE      = 3'd3,
    FN_SLEEP     = 3'd4,
    FN_TERMINATE = 3'd5,
    FN_SCHEDULE  = 3'd6
  } func_t;

  typedef enum logic [TS_W-1:0] {
    TS_READY      = 2'd0,
    TS_BLOCKED    = 2'd1,
    TS_SLEEPING   = 2'd2,
    TS_TERMINATED = 2'd3
  } task_state_t;

  localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_IGNORED = 2'd2;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_EDIT,
    CS_ADD,
    CS_SCH_ISSUE,
    CS_SCH_CHECK
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld;
    logic mul;
    logic edit;
    logic add_step;
    logic sch_issue;
    logic sch_check;
  } rrts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic add_done;
    logic sch_hit;
  } rrts_stat_t;

endpackage

/* hdl/rrts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/rrts_ctrl.sv */
// Sequencing state machine of the round-robin task selector.
`include "assert_macros.svh"

module rrts_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rrts_pkg::FUNC_W-1:0]    in_func,
  input  rrts_pkg::rrts_stat_t           stat,
  output rrts_pkg::rrts_cmd_t            cmd,
  output logic                           busy
);

  import rrts_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (start) begin
          case (in_func)
            FN_ADD:      state_nxt = CS_ADD;
            FN_SCHEDULE: state_nxt = CS_SCH_ISSUE;
            FN_SLEEP:    state_nxt = CS_MUL;
            default:     state_nxt = CS_EDIT;
          endcase
        end
      end
      CS_MUL:       state_nxt = CS_EDIT;
      CS_EDIT:      state_nxt = CS_IDLE;
      CS_ADD: begin
        if (stat.add_done) begin
          state_nxt = CS_IDLE;
        end
      end
      CS_SCH_ISSUE: state_nxt = CS_SCH_CHECK;
      CS_SCH_CHECK: begin
        if (stat.sch_hit) begin
          state_nxt = CS_IDLE;
        end
      end
      default:      state_nxt = CS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd           = '0;
    busy          = (state_r != CS_IDLE);
    cmd.ld        = (state_r == CS_IDLE) && start;
    cmd.mul       = (state_r == CS_MUL);
    cmd.edit      = (state_r == CS_EDIT);
    cmd.add_step  = (state_r == CS_ADD);
    cmd.sch_issue = (state_r == CS_SCH_ISSUE);
    cmd.sch_check = (state_r == CS_SCH_CHECK);
  end

  `ASSERT_SYNC(a_accept_busy, clk, rst_n, start && !busy |=> busy, "accepted beat left block idle")
  `ASSERT_SYNC(a_edit_one, clk, rst_n, state_r == CS_EDIT |=> state_r == CS_IDLE, "edit lasted more than one cycle")
  `ASSERT_SYNC(a_mul_edit, clk, rst_n, state_r == CS_MUL |=> state_r == CS_EDIT, "multiply not followed by edit")

endmodule

/* hdl/rrts_dp.sv */
// Task table, scan pointers and result registers of the task selector.
`include "assert_macros.svh"

module rrts_dp #(
  parameter int TABLE_SLOTS = rrts_pkg::DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rrts_pkg::rrts_cmd_t            cmd,
  output rrts_pkg::rrts_stat_t           stat,
  input  logic [rrts_pkg::FUNC_W-1:0]    in_func,
  input  logic [rrts_pkg::PID_W-1:0]     in_pid,
  input  logic [rrts_pkg::WORD_W-1:0]    in_sleep_us,
  input  logic [rrts_pkg::WORD_W-1:0]    in_now_tick,
  input  logic                           cfg_we,
  input  logic [rrts_pkg::TPU_W-1:0]     cfg_ticks_per_us,
  output logic                           out_valid,
  output logic [rrts_pkg::PID_W-1:0]     out_pid_out,
  output logic [rrts_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_switched
);

  import rrts_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int WIDE_W = (SLOT_W > PID_W) ? SLOT_W : PID_W;
  localparam int ENT_W  = TS_W + WORD_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] n);
    return (n == LAST_SLOT) ? '0 : SLOT_W'(n + 1'b1);
  endfunction

  function automatic logic [PID_W-1:0] to_pid(input logic [SLOT_W-1:0] n);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(n);
    return w[PID_W-1:0];
  endfunction

  // Latched item.
  logic [FUNC_W-1:0]        func_r;
  logic [PID_W-1:0]         pid_r;
  logic [WORD_W-1:0]        sleep_r;
  logic [WORD_W-1:0]        now_r;
  logic [TPU_W-1:0]         tpu_r;
  logic [WORD_W-1:0]        prod_r;
  logic [WORD_W+TPU_W-1:0]  mul_full;

  // Table state.
  logic [TABLE_SLOTS-1:0]   used_r, used_nxt;
  logic [SLOT_W-1:0]        cur_r, cur_nxt;
  logic [SLOT_W-1:0]        addr_r, addr_nxt;
  logic [SLOT_W-1:0]        rd_slot_r, rd_slot_nxt;

  // Results.
  logic                     out_valid_r;
  logic [PID_W-1:0]         pid_out_r;
  logic [STATUS_W-1:0]      status_r;
  logic                     switched_r;

  // RAM port.
  logic                     ram_we;
  logic [SLOT_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]         ram_wdata;
  logic [SLOT_W-1:0]        ram_raddr;
  logic [ENT_W-1:0]         ram_rdata;

  // Combinational decisions.
  logic [WIDE_W-1:0]        pid_wide;
  logic [SLOT_W-1:0]        pidx;
  logic                     editable;
  logic [TS_W-1:0]          rd_state;
  logic [WORD_W-1:0]        wake_diff;
  logic                     asleep;
  logic                     fin;
  logic                     hit;
  logic                     issue;
  logic [PID_W-1:0]         res_pid;
  logic [STATUS_W-1:0]      res_status;
  logic                     res_sw;
  logic [TS_W-1:0]          edit_state;

  rrts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_task_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mul_full  = sleep_r * tpu_r;
  assign pid_wide  = WIDE_W'(pid_r);
  assign pidx      = pid_wide[SLOT_W-1:0];
  assign editable  = (pid_r != '0) && (int'(pid_r) < TABLE_SLOTS) && used_r[pidx];
  // The idle slot is never written, so force it ready.
  assign rd_state  = (rd_slot_r == '0) ? TS_READY : ram_rdata[ENT_W-1:WORD_W];
  assign wake_diff = ram_rdata[WORD_W-1:0] - now_r;
  assign asleep    = (wake_diff != '0) && !wake_diff[WORD_W-1];

  always_comb begin
    case (func_r)
      FN_BLOCK: edit_state = TS_BLOCKED;
      FN_WAKE:  edit_state = TS_READY;
      default:  edit_state = TS_TERMINATED;
    endcase
  end

  always_comb begin
    used_nxt    = used_r;
    cur_nxt     = cur_r;
    addr_nxt    = addr_r;
    rd_slot_nxt = rd_slot_r;
    ram_we      = 1'b0;
    ram_waddr   = pidx;
    ram_wdata   = {TS_READY, now_r};
    ram_raddr   = addr_r;
    fin         = 1'b0;
    hit         = 1'b0;
    issue       = cmd.sch_issue;
    res_pid     = to_pid(cur_r);
    res_status  = STS_DONE;
    res_sw      = 1'b0;

    if (cmd.ld) begin
      addr_nxt = (in_func == FN_SCHEDULE) ? next_slot(cur_r) : SLOT_W'(1);
    end

    if (cmd.edit) begin
      fin = 1'b1;
      case (func_r)
        FN_REMOVE: begin
          if (editable) begin
            used_nxt[pidx] = 1'b0;
          end else begin
            res_status = STS_IGNORED;
          end
        end
        FN_BLOCK, FN_WAKE, FN_TERMINATE: begin
          if (editable) begin
            ram_we    = 1'b1;
            ram_wdata = {edit_state, now_r};
          end else begin
            res_status = STS_IGNORED;
          end
        end
        FN_SLEEP: begin
          if (sleep_r != '0) begin
            if (editable) begin
              ram_we    = 1'b1;
              ram_wdata = {TS_SLEEPING, now_r + prod_r};
            end else begin
              res_status = STS_IGNORED;
            end
          end
        end
        default: res_status = STS_IGNORED;
      endcase
    end

    if (cmd.add_step) begin
      if (!used_r[addr_r]) begin
        used_nxt[addr_r] = 1'b1;
        ram_we           = 1'b1;
        ram_waddr        = addr_r;
        ram_wdata        = {TS_READY, now_r};
        fin              = 1'b1;
        res_pid          = to_pid(addr_r);
      end else if (addr_r == LAST_SLOT) begin
        fin        = 1'b1;
        res_status = STS_FULL;
      end else begin
        addr_nxt = SLOT_W'(addr_r + 1'b1);
      end
    end

    if (cmd.sch_check) begin
      if (used_r[rd_slot_r]) begin
        case (rd_state)
          TS_BLOCKED:    hit = 1'b0;
          TS_TERMINATED: used_nxt[rd_slot_r] = 1'b0;
          TS_SLEEPING: begin
            if (!asleep) begin
              hit       = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = rd_slot_r;
              ram_wdata = {TS_READY, now_r};
            end
          end
          default:       hit = 1'b1;
        endcase
      end
      if (hit) begin
        fin     = 1'b1;
        cur_nxt = rd_slot_r;
        res_pid = to_pid(rd_slot_r);
        res_sw  = (rd_slot_r != cur_r);
      end else begin
        issue = 1'b1;
      end
    end

    // Fetch the next slot while the current one is checked.
    if (issue) begin
      ram_raddr   = addr_r;
      rd_slot_nxt = addr_r;
      addr_nxt    = next_slot(addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= TABLE_SLOTS'(1);
      cur_r       <= '0;
      tpu_r       <= TPU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= fin;
      if (cfg_we) begin
        tpu_r <= cfg_ticks_per_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    rd_slot_r <= rd_slot_nxt;
    if (cmd.ld) begin
      func_r  <= in_func;
      pid_r   <= in_pid;
      sleep_r <= in_sleep_us;
      now_r   <= in_now_tick;
    end
    if (cmd.mul) begin
      prod_r <= mul_full[WORD_W-1:0];
    end
    if (fin) begin
      pid_out_r  <= res_pid;
      status_r   <= res_status;
      switched_r <= res_sw;
    end
  end

  assign stat.add_done = cmd.add_step && fin;
  assign stat.sch_hit  = hit;

  assign out_valid    = out_valid_r;
  assign out_pid_out  = pid_out_r;
  assign out_status   = status_r;
  assign out_switched = switched_r;

  `ASSERT_SYNC(a_idle_used, clk, rst_n, used_r[0], "idle slot lost its used flag")
  `ASSERT_SYNC(a_one_beat, clk, rst_n, out_valid_r |=> !out_valid_r, "result strobe held two cycles")
  `ASSERT_SYNC(a_hit_used, clk, rst_n, cmd.sch_check && hit |-> used_r[rd_slot_r], "schedule picked a free slot")

endmodule

/* hdl/round_robin_task_selector.sv */
// Top level of the round-robin task selector: controller, datapath, config port.
//
// Pulse start with an operation on the in_ ports while busy is low; the beat is
// taken at that edge and busy rises until the block can take the next one.
// Every operation returns exactly one result beat: out_valid is high for one
// cycle with out_pid_out, out_status and out_switched, and the receiver must
// take it then, as there is no back-pressure. Remove, block, wake,
// mark-terminated and unused codes pass through the edit state; sleep first
// passes through a multiply state for the 32x10 tick multiply and then the
// edit state; add steps through the slots up to the first free one, or up to
// the last slot when the table is full; schedule issues the first read and
// then checks the slots it visits. Add and schedule walk the table one slot
// per cycle: add over the used flags, schedule through the single read port
// of the task RAM that holds each slot's state and wake tick. busy drops in
// the cycle the result is shown, so a new start may be taken alongside the
// strobe. No clearing pass runs after reset: free slots are skipped through
// their used flags and the idle slot is always ready.
// ticks_per_us is written through cfg_valid/cfg_ready, ready while idle.
module round_robin_task_selector #(
  parameter int TABLE_SLOTS = rrts_pkg::DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [rrts_pkg::FUNC_W-1:0]    in_func,
  input  logic [rrts_pkg::PID_W-1:0]     in_pid,
  input  logic [rrts_pkg::WORD_W-1:0]    in_sleep_us,
  input  logic [rrts_pkg::WORD_W-1:0]    in_now_tick,
  // result channel
  output logic                           out_valid,
  output logic [rrts_pkg::PID_W-1:0]     out_pid_out,
  output logic [rrts_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_switched,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrts_pkg::TPU_W-1:0]     cfg_ticks_per_us
);

  import rrts_pkg::*;

  rrts_cmd_t  cmd;
  rrts_stat_t stat;

  // Take config beats only while no operation is in flight.
  assign cfg_ready = !busy;

  rrts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  rrts_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_pid           (in_pid),
    .in_sleep_us      (in_sleep_us),
    .in_now_tick      (in_now_tick),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_ticks_per_us (cfg_ticks_per_us),
    .out_valid        (out_valid),
    .out_pid_out      (out_pid_out),
    .out_status       (out_status),
    .out_switched     (out_switched)
  );

endmodule

/* verif/rrts_checker.sv */
// Scoreboard of the round-robin task selector: mirrors the task table and checks result beats.
module rrts_checker #(
  parameter int SLOTS = rrts_pkg::DEF_TABLE_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [rrts_pkg::FUNC_W-1:0]   in_func,
  input  logic [rrts_pkg::PID_W-1:0]    in_pid,
  input  logic [rrts_pkg::WORD_W-1:0]   in_sleep_us,
  input  logic [rrts_pkg::WORD_W-1:0]   in_now_tick,
  input  logic                          out_valid,
  input  logic [rrts_pkg::PID_W-1:0]    out_pid_out,
  input  logic [rrts_pkg::STATUS_W-1:0] out_status,
  input  logic                          out_switched,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rrts_pkg::TPU_W-1:0]    cfg_ticks_per_us,
  output int                            mismatches,
  output int                            outstanding
);

  import rrts_pkg::*;

  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [STATUS_W-1:0] status;
    logic                switched;
  } pick_t;

  logic              slot_taken [SLOTS];
  task_state_t       slot_mode  [SLOTS];
  logic [WORD_W-1:0] slot_wake  [SLOTS];
  int                running_pid;
  logic [TPU_W-1:0]  tick_scale;
  pick_t             picks_due [$];
  int                fail_cnt = 0;

  // Apply one operation to the mirrored table and return the result beat it owes.
  function automatic pick_t run_table_op(input logic [FUNC_W-1:0] op,
                                         input logic [PID_W-1:0]  pid,
                                         input logic [WORD_W-1:0] sleep_us,
                                         input logic [WORD_W-1:0] now);
    pick_t             r;
    logic              editable;
    logic              found;
    logic [WORD_W-1:0] gap;
    int                n;
    r.pid      = PID_W'(running_pid);
    r.status   = STS_DONE;
    r.switched = 1'b0;
    found      = 1'b0;
    editable   = (pid != '0) && (int'(pid) < SLOTS) && slot_taken[pid];
    case (op)
      FN_ADD: begin
        r.status = STS_FULL;
        for (int i = 1; i < SLOTS && !found; i++) begin
          if (!slot_taken[i]) begin
            slot_taken[i] = 1'b1;
            slot_mode[i]  = TS_READY;
            r.pid         = PID_W'(i);
            r.status      = STS_DONE;
            found         = 1'b1;
          end
        end
      end
      FN_REMOVE: begin
        if (editable) begin
          slot_taken[pid] = 1'b0;
          slot_mode[pid]  = TS_READY;
        end else begin
          r.status = STS_IGNORED;
        end
      end
      FN_BLOCK, FN_WAKE, FN_TERMINATE: begin
        if (!editable) begin
          r.status = STS_IGNORED;
        end else if (op == FN_BLOCK) begin
          slot_mode[pid] = TS_BLOCKED;
        end else if (op == FN_WAKE) begin
          slot_mode[pid] = TS_READY;
        end else begin
          slot_mode[pid] = TS_TERMINATED;
        end
      end
      FN_SLEEP: begin
        if (sleep_us != '0) begin
          if (editable) begin
            slot_wake[pid] = now + sleep_us * tick_scale;
            slot_mode[pid] = TS_SLEEPING;
          end else begin
            r.status = STS_IGNORED;
          end
        end
      end
      FN_SCHEDULE: begin
        n = running_pid;
        for (int k = 0; k < SLOTS && !found; k++) begin
          n = (n + 1) % SLOTS;
          if (slot_taken[n] && slot_mode[n] != TS_BLOCKED) begin
            if (slot_mode[n] == TS_TERMINATED) begin
              if (n != 0) begin
                slot_taken[n] = 1'b0;
                slot_mode[n]  = TS_READY;
              end
            end else begin
              gap = slot_wake[n] - now;
              // a sleeper stays put while its wake tick is strictly ahead
              if (!(slot_mode[n] == TS_SLEEPING && gap != '0 && !gap[WORD_W-1])) begin
                slot_mode[n] = TS_READY;
                if (n != running_pid) r.switched = 1'b1;
                running_pid = n;
                found       = 1'b1;
              end
            end
          end
        end
        r.pid = PID_W'(running_pid);
      end
      default: r.status = STS_IGNORED;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pick_t got;
    pick_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_taken[i] = (i == 0);
        slot_mode[i]  = TS_READY;
        slot_wake[i]  = '0;
      end
      running_pid = 0;
      tick_scale  = TPU_RESET;
      picks_due.delete();
    end else begin
      // retire the beat on the strobe before taking a command on the same edge
      if (out_valid) begin
        got = '{out_pid_out, out_status, out_switched};
        if (picks_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result beat with nothing pending: pid %0d status %0d switched %0d",
                     $time, got.pid, got.status, got.switched);
        end else begin
          want = picks_due.pop_front();
          if (got.pid !== want.pid || got.status !== want.status ||
              got.switched !== want.switched) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch: want pid %0d st %0d sw %0d, got pid %0d st %0d sw %0d",
                       $time, want.pid, want.status, want.switched,
                       got.pid, got.status, got.switched);
          end
        end
      end
      if (cfg_valid && cfg_ready) tick_scale = cfg_ticks_per_us;
      if (start && !busy)
        picks_due.push_back(run_table_op(in_func, in_pid, in_sleep_us, in_now_tick));
    end
    mismatches  <= fail_cnt;
    outstanding <= picks_due.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top of the round-robin task selector: clock, reset, command stimulus and verdict.
module tb_top;
  import rrts_pkg::*;

  // The one code the block must reject as unknown.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  // Operation mixes for the random part.
  localparam int MIX_FILL   = 0;  // mostly adds, drives the table to full
  localparam int MIX_STEADY = 1;  // balanced traffic on a busy table
  localparam int MIX_CHURN  = 2;  // heavy removal and termination

  // Cumulative weights out of 100: add, remove, block, wake, sleep, terminate,
  // schedule; the remainder goes to the unused code.
  localparam int MIX_CUTS [3][7] = '{'{55, 58, 63, 68, 75, 77, 99},
                                     '{18, 26, 36, 48, 62, 68, 98},
                                     '{10, 35, 42, 52, 64, 76, 98}};
  localparam logic [FUNC_W-1:0] MIX_OPS [7] = '{FN_ADD, FN_REMOVE, FN_BLOCK, FN_WAKE,
                                                FN_SLEEP, FN_TERMINATE, FN_SCHEDULE};

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   in_func;
  logic [PID_W-1:0]    in_pid;
  logic [WORD_W-1:0]   in_sleep_us;
  logic [WORD_W-1:0]   in_now_tick;
  logic                out_valid;
  logic [PID_W-1:0]    out_pid_out;
  logic [STATUS_W-1:0] out_status;
  logic                out_switched;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [TPU_W-1:0]    cfg_ticks_per_us;
  int                  mismatches;
  int                  outstanding;

  int                  idle_pct = 0;   // chance of holding start low per free cycle
  logic [WORD_W-1:0]   tick_now = '0;  // free-running timer as the block would see it

  always #5 clk = ~clk;

  round_robin_task_selector i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_pid           (in_pid),
    .in_sleep_us      (in_sleep_us),
    .in_now_tick      (in_now_tick),
    .out_valid        (out_valid),
    .out_pid_out      (out_pid_out),
    .out_status       (out_status),
    .out_switched     (out_switched),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_ticks_per_us (cfg_ticks_per_us)
  );

  rrts_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_pid           (in_pid),
    .in_sleep_us      (in_sleep_us),
    .in_now_tick      (in_now_tick),
    .out_valid        (out_valid),
    .out_pid_out      (out_pid_out),
    .out_status       (out_status),
    .out_switched     (out_switched),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_ticks_per_us (cfg_ticks_per_us),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Present one command and hold it until the block takes it. Gaps are only
  // counted once the block is free, so they land right after busy drops, at
  // random offsets into the next idle window. Start stays high on return so a
  // back-to-back command never lowers and raises it in the same step.
  task automatic issue_op(input logic [FUNC_W-1:0] op, input logic [PID_W-1:0] pid,
                          input logic [WORD_W-1:0] us, input logic [WORD_W-1:0] now);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy || $urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    start       <= 1'b1;
    in_func     <= op;
    in_pid      <= pid;
    in_sleep_us <= us;
    in_now_tick <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and hold off until every pending result beat has come back.
  // The first edge lets the checker see a command taken on the last edge.
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write ticks_per_us on an idle block.
  task automatic write_tick_scale(input logic [TPU_W-1:0] scale);
    hold_until_drained();
    cfg_valid        <= 1'b1;
    cfg_ticks_per_us <= scale;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random command: well-formed table traffic on low slots most of the
  // time, with full-range slots, sleep lengths and timer jumps mixed in.
  task automatic issue_random_op(input int mix);
    logic [FUNC_W-1:0] op;
    logic [PID_W-1:0]  pid;
    logic [WORD_W-1:0] us;
    int                r;
    r  = $urandom_range(0, 99);
    op = FN_UNUSED;
    for (int k = 6; k >= 0; k--)
      if (r < MIX_CUTS[mix][k]) op = MIX_OPS[k];
    pid = ($urandom_range(0, 99) < 70) ? PID_W'($urandom_range(0, 20))
                                       : PID_W'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < 10)      us = '0;
    else if (r < 25) us = $urandom;
    else             us = $urandom_range(1, 20);
    // advance the timer; now and then jump anywhere, wrap included
    if ($urandom_range(0, 99) < 5) tick_now = $urandom;
    else                           tick_now = tick_now + $urandom_range(0, 800);
    issue_op(op, pid, us, tick_now);
  endtask

  // One random phase: new tick scale on an idle block, then a run of commands.
  task automatic run_phase(input logic [TPU_W-1:0] scale, input int gap_pct,
                           input int mix, input int count);
    write_tick_scale(scale);
    idle_pct = gap_pct;
    for (int n = 0; n < count; n++) begin
      // now and then let the block run dry before going on
      if ($urandom_range(0, 99) == 0) hold_until_drained();
      issue_random_op(mix);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_func          <= FN_ADD;
    in_pid           <= '0;
    in_sleep_us      <= '0;
    in_now_tick      <= '0;
    cfg_valid        <= 1'b0;
    cfg_ticks_per_us <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, ticks_per_us at its reset value of one.
    // Only the idle task exists: schedule keeps it.
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd0);
    // Edits of the idle slot and of a free slot are ignored.
    issue_op(FN_REMOVE,    6'd0,  32'd0, 32'd0);
    issue_op(FN_BLOCK,     6'd0,  32'd0, 32'd0);
    issue_op(FN_SLEEP,     6'd0,  32'd5, 32'd0);
    issue_op(FN_WAKE,      6'd63, 32'd0, 32'd0);
    issue_op(FN_UNUSED,    6'd0,  32'd0, 32'd0);
    // Claim slots 1 to 3.
    issue_op(FN_ADD,       6'd0,  32'd0, 32'd0);
    issue_op(FN_ADD,       6'd0,  32'd0, 32'd0);
    issue_op(FN_ADD,       6'd0,  32'd0, 32'd0);
    // Zero sleep length is done and changes nothing, even on a free slot.
    issue_op(FN_SLEEP,     6'd2,  32'd0, 32'd0);
    issue_op(FN_SLEEP,     6'd63, 32'd0, 32'd0);
    // Slot 2 sleeps until tick 1100, slot 3 blocks.
    issue_op(FN_SLEEP,     6'd2,  32'd100, 32'd1000);
    issue_op(FN_BLOCK,     6'd3,  32'd0, 32'd0);
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd1000);
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd1050);
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd1100);
    // Wake tick equal to now: the sleeper is due.
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd1100);
    issue_op(FN_WAKE,      6'd3,  32'd0, 32'd0);
    issue_op(FN_TERMINATE, 6'd1,  32'd0, 32'd0);
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd1200);
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd1200);
    // The scan frees the terminated slot 1 on its way to slot 2.
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd1200);
    // Remove the current task; the next scan starts after it.
    issue_op(FN_REMOVE,    6'd2,  32'd0, 32'd0);
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd1300);
    // Largest sleep on the largest tick wraps the wake tick modulo 2^32.
    issue_op(FN_SLEEP,     6'd3,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd0);
    issue_op(FN_SCHEDULE,  6'd0,  32'd0, 32'd0);
    issue_op(FN_ADD,       6'd0,  32'd0, 32'd0);

    // Random phases: every tick scale extreme, gap pressure varied per phase.
    run_phase(10'd1000, 0,  MIX_FILL,   150);
    run_phase(10'd0,    70, MIX_STEADY, 150);
    run_phase(10'd1023, 0,  MIX_CHURN,  150);
    run_phase(TPU_W'($urandom_range(1, 1000)), 29, MIX_STEADY, 150);
    run_phase(10'd1,    70, MIX_FILL,   150);
    run_phase(10'd512,  0,  MIX_STEADY, 150);

    // Drain, then leave room for any stray beat after the longest scan.
    hold_until_drained();
    repeat (DEF_TABLE_SLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest run of full-length scans and idle gaps.
  initial begin
    #(10 * 1_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
